/* design/mbe_pkg.sv */
// Shared types, constants and helpers for the Mandelbrot escape-time color unit.
package mbe_pkg;

  localparam int COORD_W = 32;
  localparam int COUNT_W = 16;
  localparam int FRAC_W  = COORD_W - 4;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int WIDE_W  = PROD_W + 2;
  localparam int RED_W   = 11;
  localparam int BLUE_W  = 8;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(2000);
  localparam logic [BLUE_W-1:0]  BLUE_MAX    = {BLUE_W{1'b1}};
  localparam logic [WIDE_W-1:0]  ESC_THRESH  = WIDE_W'(1) << (2 * FRAC_W + 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_XX,
    S_YY,
    S_XY,
    S_UPD,
    S_DONE
  } state_t;

  // floor by FRAC_W, then clamp to the signed coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-FRAC_W-COORD_W:0] top;
    top = v[WIDE_W-1:FRAC_W+COORD_W-1];
    if (top == '0 || top == '1) begin
      return v[FRAC_W+COORD_W-1:FRAC_W];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

/* design/mandelbrot_escape_time_color_unit.sv */
// Mandelbrot escape-time evaluator with red/blue color codes; one shared multiplier.
// Each iteration: one multiplier does x*x, y*y and x*y in turn, then an update step;
//   a point finishes when it escapes or when the iteration limit N is reached.
// Throughput: one item at a time; in_stall is high from accept until the result is loaded.
// The result register frees the input side while a result waits on out_stall.
// Reset (rst, synchronous): idle, no result held, iteration_limit back to 2000.
module mandelbrot_escape_time_color_unit import mbe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [COUNT_W-1:0]        iteration_limit,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] c_real,
  input  logic signed [COORD_W-1:0] c_imag,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COUNT_W-1:0]        escape_count,
  output logic                      inside_set,
  output logic [RED_W-1:0]          red_code,
  output logic [BLUE_W-1:0]         blue_code
);

  state_t state, state_next;

  logic [COUNT_W-1:0]        iter_limit;
  logic signed [COORD_W-1:0] cr, ci, x, y;
  logic [COUNT_W-1:0]        count;
  logic signed [PROD_W-1:0]  prod, xx;
  logic signed [COORD_W-1:0] mul_a, mul_b;
  logic [WIDE_W-1:0]         sum_sq;
  logic signed [WIDE_W-1:0]  cr_al, ci_al, nx_sum, ny_sum;
  logic                      escape, at_limit, in_accept, load_out;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign at_limit  = (count == iter_limit);

  // shared multiplier operands
  assign mul_a = (state == S_YY) ? y : x;
  assign mul_b = (state == S_XX) ? x : y;

  assign cr_al  = {{(WIDE_W-COORD_W-FRAC_W){cr[COORD_W-1]}}, cr, {FRAC_W{1'b0}}};
  assign ci_al  = {{(WIDE_W-COORD_W-FRAC_W){ci[COORD_W-1]}}, ci, {FRAC_W{1'b0}}};
  assign sum_sq = {2'b00, xx} + {2'b00, prod};
  assign escape = (sum_sq >= ESC_THRESH);
  assign nx_sum = {{2{xx[PROD_W-1]}}, xx} - {{2{prod[PROD_W-1]}}, prod} + cr_al;
  assign ny_sum = {prod[PROD_W-1], prod, 1'b0} + ci_al;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = S_XX;
        end
      end
      S_XX: begin
        state_next = at_limit ? S_DONE : S_YY;
      end
      S_YY: begin
        state_next = S_XY;
      end
      S_XY: begin
        state_next = escape ? S_DONE : S_UPD;
      end
      S_UPD: begin
        state_next = S_XX;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      iter_limit <= iteration_limit;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (in_accept) begin
      cr    <= c_real;
      ci    <= c_imag;
      x     <= '0;
      y     <= '0;
      count <= '0;
    end
    if (state == S_YY) begin
      xx <= prod;
    end
    // x*y is taken from the old x in this same cycle
    if (state == S_XY) begin
      x <= sat_coord(nx_sum);
    end
    if (state == S_UPD) begin
      y     <= sat_coord(ny_sum);
      count <= count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      escape_count <= count;
      inside_set   <= at_limit;
      red_code     <= at_limit ? '0 : count[RED_W-1:0];
      if (at_limit) begin
        blue_code <= '0;
      end else if (count > COUNT_W'(BLUE_MAX)) begin
        blue_code <= BLUE_MAX;
      end else begin
        blue_code <= count[BLUE_W-1:0];
      end
    end
  end

endmodule

/* design/mbe_checker.sv */
// Port-level assertions for the Mandelbrot escape-time color unit, bound to the top level.
module mbe_checker import mbe_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [COUNT_W-1:0]        escape_count,
  input logic                      inside_set,
  input logic [RED_W-1:0]          red_code,
  input logic [BLUE_W-1:0]         blue_code
);

  // an accepted item keeps the unit busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(escape_count) && $stable(inside_set))
    else $error("stalled result changed");

  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_set |-> red_code == '0 && blue_code == '0)
    else $error("inside point has nonzero color");

  a_red_map: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_set |-> red_code == escape_count[RED_W-1:0])
    else $error("red code mismatch");

  a_blue_map: assert property (@(posedge clk) disable iff (rst)
    out_valid && !inside_set |->
      ((escape_count > COUNT_W'(BLUE_MAX) && blue_code == BLUE_MAX) ||
       (escape_count <= COUNT_W'(BLUE_MAX) && blue_code == escape_count[BLUE_W-1:0])))
    else $error("blue code mismatch");

endmodule

bind mandelbrot_escape_time_color_unit mbe_checker u_mbe_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the Mandelbrot escape-time color unit.
module testbench import mbe_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               in_set;
    logic [RED_W-1:0]   red;
    logic [BLUE_W-1:0]  blue;
  } pixel_t;

  typedef struct packed {
    logic [COUNT_W-1:0]        lim;
    logic signed [COORD_W-1:0] cr;
    logic signed [COORD_W-1:0] ci;
    bit                        typed;
    pixel_t                    px;
  } point_row_t;

  localparam logic signed [COORD_W-1:0] ONE_Q  = 32'sd268435456;
  localparam logic signed [COORD_W-1:0] QTR_Q  = 32'sd67108864;
  localparam logic signed [COORD_W-1:0] CMAX_Q = 32'sh7FFFFFFF;
  localparam logic signed [COORD_W-1:0] CMIN_Q = 32'sh80000000;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX   = 66'sh7FFFFFFF;
  localparam logic signed [WIDE_W-1:0] WIDE_MIN   = -66'sh80000000;
  localparam logic signed [WIDE_W-1:0] ESC_RADIUS = 66'sd1 <<< (2 * FRAC_W + 2);

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int          NUM_PHASES  = 6;
  localparam int          PHASE_ITEMS = 45;

  localparam point_row_t DIR_ROWS [22] = '{
    '{16'd2000,  32'sd0,           32'sd0,     1'b1, '{16'd2000, 1'b1, 11'd0, 8'd0}},
    '{16'd2000,  CMAX_Q,           CMAX_Q,     1'b1, '{16'd1, 1'b0, 11'd1, 8'd1}},
    '{16'd2000,  CMIN_Q,           CMIN_Q,     1'b1, '{16'd1, 1'b0, 11'd1, 8'd1}},
    '{16'd2000,  -(2 * ONE_Q),     32'sd0,     1'b0, '0},
    '{16'd2000,  QTR_Q,            32'sd0,     1'b0, '0},
    '{16'd2000,  -(3 * QTR_Q),     ONE_Q / 10, 1'b0, '0},
    '{16'd1,     32'sd0,           32'sd0,     1'b1, '{16'd1, 1'b1, 11'd0, 8'd0}},
    '{16'd1,     CMAX_Q,           CMAX_Q,     1'b1, '{16'd1, 1'b1, 11'd0, 8'd0}},
    '{16'd0,     CMAX_Q,           32'sd0,     1'b1, '{16'd0, 1'b1, 11'd0, 8'd0}},
    '{16'd0,     32'sd0,           32'sd0,     1'b1, '{16'd0, 1'b1, 11'd0, 8'd0}},
    '{16'd0,     CMIN_Q,           CMAX_Q,     1'b1, '{16'd0, 1'b1, 11'd0, 8'd0}},
    '{16'd65535, 32'sd0,           32'sd0,     1'b1, '{16'd65535, 1'b1, 11'd0, 8'd0}},
    '{16'd65535, CMIN_Q,           32'sd0,     1'b1, '{16'd1, 1'b0, 11'd1, 8'd1}},
    '{16'd65535, CMAX_Q,           CMIN_Q,     1'b1, '{16'd1, 1'b0, 11'd1, 8'd1}},
    '{16'd4095,  QTR_Q + 300,      32'sd0,     1'b0, '0},
    '{16'd4095,  QTR_Q + 1000,     32'sd0,     1'b0, '0},
    '{16'd300,   QTR_Q + 40000,    32'sd0,     1'b0, '0},
    '{16'd300,   32'sd0,           2 * ONE_Q,  1'b1, '{16'd1, 1'b0, 11'd1, 8'd1}},
    '{16'd300,   -(2 * ONE_Q),     ONE_Q / 1000, 1'b0, '0},
    '{16'd300,   -(3 * QTR_Q),     32'sd0,     1'b0, '0},
    '{16'd256,   QTR_Q + 40000,    32'sd0,     1'b0, '0},
    '{16'd256,   ONE_Q / 2,        ONE_Q / 2,  1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_limit;
  logic in_valid;
  logic in_stall;
  logic signed [COORD_W-1:0] c_real;
  logic signed [COORD_W-1:0] c_imag;
  logic out_valid;
  logic out_stall;
  logic [COUNT_W-1:0] escape_count;
  logic inside_set;
  logic [RED_W-1:0] red_code;
  logic [BLUE_W-1:0] blue_code;

  pixel_t color_q [$];
  logic [COUNT_W-1:0] cur_limit = LIMIT_RESET;
  int unsigned bad_px = 0;
  int unsigned cycle_cnt = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req = 1'b0;

  mandelbrot_escape_time_color_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .iteration_limit(cfg_limit),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .c_real         (c_real),
    .c_imag         (c_imag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .escape_count   (escape_count),
    .inside_set     (inside_set),
    .red_code       (red_code),
    .blue_code      (blue_code)
  );

  always #10 clk = ~clk;

  // floor by the fraction width, clamp to the coordinate range
  function automatic logic signed [WIDE_W-1:0] clamp_coord(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] s;
    s = v >>> FRAC_W;
    if (s > WIDE_MAX) begin
      return WIDE_MAX;
    end else if (s < WIDE_MIN) begin
      return WIDE_MIN;
    end
    return s;
  endfunction

  function automatic pixel_t escape_point(input logic signed [COORD_W-1:0] cr,
                                          input logic signed [COORD_W-1:0] ci,
                                          input logic [COUNT_W-1:0] lim);
    logic signed [WIDE_W-1:0] x, y, xx, yy, xy, crw, ciw;
    int unsigned n;
    pixel_t p;
    x = '0;
    y = '0;
    n = 0;
    crw = WIDE_W'(cr);
    crw = crw <<< FRAC_W;
    ciw = WIDE_W'(ci);
    ciw = ciw <<< FRAC_W;
    while (n < 32'(lim)) begin
      xx = x * x;
      yy = y * y;
      if (xx + yy >= ESC_RADIUS) break;
      xy = x * y;
      x = clamp_coord(xx - yy + crw);
      y = clamp_coord(xy + xy + ciw);
      n++;
    end
    p.count  = n[COUNT_W-1:0];
    p.in_set = (n == 32'(lim));
    p.red    = p.in_set ? '0 : n[RED_W-1:0];
    p.blue   = p.in_set ? '0 : (n > 32'(BLUE_MAX) ? BLUE_MAX : n[BLUE_W-1:0]);
    return p;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!tx_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic random_point(output logic signed [COORD_W-1:0] cr,
                              output logic signed [COORD_W-1:0] ci);
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 70) begin
      // the plot window: real -2.25..0.75, imag -1.5..1.5
      cr = $urandom_range(0, 805306368) - 603979776;
      ci = $urandom_range(0, 805306368) - 402653184;
    end else if (k < 80) begin
      cr = $urandom;
      ci = $urandom;
    end else if (k < 90) begin
      // just past the cusp: long escapes
      cr = QTR_Q + $urandom_range(0, 1 << 18);
      ci = $urandom_range(0, 1 << 16) - (1 << 15);
    end else begin
      // around the neck at -0.75
      cr = -(3 * QTR_Q) + $urandom_range(0, 1 << 20) - (1 << 19);
      ci = $urandom_range(0, 1 << 22) - (1 << 21);
    end
  endtask

  task automatic send_point(input logic signed [COORD_W-1:0] cr,
                            input logic signed [COORD_W-1:0] ci,
                            input bit typed, input pixel_t want);
    int unsigned gap;
    in_valid <= 1'b1;
    c_real   <= cr;
    c_imag   <= ci;
    do @(posedge clk); while (in_stall);
    color_q.push_back(typed ? want : escape_point(cr, ci, cur_limit));
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_limit = v;
  endtask

  // result side
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (color_q.size() == 0) begin
        bad_px++;
        if (bad_px <= 10)
          $display("unexpected item: count %0d inside %0d red %0d blue %0d",
                   escape_count, inside_set, red_code, blue_code);
      end else begin
        want = color_q.pop_front();
        if (escape_count !== want.count || inside_set !== want.in_set ||
            red_code !== want.red || blue_code !== want.blue) begin
          bad_px++;
          if (bad_px <= 10)
            $display("mismatch: expected count %0d inside %0d red %0d blue %0d, got %0d %0d %0d %0d",
                     want.count, want.in_set, want.red, want.blue,
                     escape_count, inside_set, red_code, blue_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : rx_side
    int unsigned stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : tx_side
    logic signed [COORD_W-1:0] cr, ci;
    logic [COUNT_W-1:0] phase_lim [NUM_PHASES];
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_limit <= '0;
    in_valid  <= 1'b0;
    c_real    <= '0;
    c_imag    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].lim != cur_limit) begin
        drain();
        write_limit(DIR_ROWS[i].lim);
      end
      send_point(DIR_ROWS[i].cr, DIR_ROWS[i].ci, DIR_ROWS[i].typed, DIR_ROWS[i].px);
    end

    phase_lim[0] = 16'd300;
    phase_lim[1] = 16'd17;
    phase_lim[2] = COUNT_W'($urandom_range(2, 64));
    phase_lim[3] = 16'd256;
    phase_lim[4] = COUNT_W'($urandom_range(1, 255));
    phase_lim[5] = 16'd1000;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      write_limit(phase_lim[ph]);
      tx_idle_on = (ph != 0);
      rx_idle_on = (ph != 0);
      // receiver holds off while items keep coming
      if (ph == 1) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == PHASE_ITEMS / 2) drain();
        random_point(cr, ci);
        send_point(cr, ci, 1'b0, '0);
      end
    end

    drain();
    repeat (60) @(posedge clk);
    if (bad_px == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
design/mbe_pkg.sv
design/mandelbrot_escape_time_color_unit.sv
design/mbe_checker.sv
tb/testbench.sv
